@@ rtl/assert_macros.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/lav_pkg.sv @@
package lav_pkg;

    // default fraction width of the Q format
    localparam int FRAC_BITS_DEF = 16;

    // index of the last column of one matrix
    localparam logic [1:0] LAST_COL = 2'd3;

    typedef logic [2:0][31:0] t_vec3;
    typedef logic [2:0][63:0] t_vec3w;

    // payload riding along the upn x n product and its normalization
    typedef struct packed {
        logic  deg;
        t_vec3 n;
        t_vec3 pos;
    } t_side1;

    // payload riding along the n x u product
    typedef struct packed {
        logic  deg;
        t_vec3 u;
        t_vec3 n;
        t_vec3 pos;
    } t_side2;

    // finished view matrix
    typedef struct packed {
        logic  deg;
        t_vec3 u;
        t_vec3 v;
        t_vec3 n;
        t_vec3 t;
    } t_mat;

    function automatic logic [63:0] abs64(input logic [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

endpackage

@@ rtl/look_at_view_matrix_top.sv @@
// Look-at view matrix, Q(31-F).F fixed point, fully pipelined datapath.
// Column 0 comes out first, columns 1..3 follow.
// A new camera request is not accepted while busy is high; the spacing is set by the four-column result port.
// busy is high after an accept until the request gap counter runs down; results cannot be stalled.
// Synchronous active-low reset clears all valid bits and the column counter.
`include "assert_macros.svh"

module look_at_view_matrix_top #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    input  logic signed [31:0] i_up_x,
    input  logic signed [31:0] i_up_y,
    input  logic signed [31:0] i_up_z,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    output logic               o_strobe,
    output logic [1:0]         o_column_index,
    output logic signed [31:0] o_entry_row0,
    output logic signed [31:0] o_entry_row1,
    output logic signed [31:0] o_entry_row2,
    output logic signed [31:0] o_entry_row3,
    output logic               o_last_column,
    output logic               o_degenerate
);

    logic [1:0]      r_gap;
    logic            acc;
    lav_pkg::t_vec3w dir_w;
    lav_pkg::t_vec3w up_w;
    lav_pkg::t_vec3  pos_in;
    logic            v_d;
    logic            v_u;
    lav_pkg::t_vec3  n_vec;
    lav_pkg::t_vec3  upn_vec;
    logic            z_d;
    logic            z_u;
    lav_pkg::t_vec3  pos_d;
    lav_pkg::t_side1 side1;
    logic            v_c1;
    lav_pkg::t_vec3w w1;
    lav_pkg::t_side1 side1_c;
    logic            v_nw;
    lav_pkg::t_vec3  u_vec;
    logic            z_w;
    lav_pkg::t_side1 side1_n;
    lav_pkg::t_side2 side2;
    logic            v_c2;
    lav_pkg::t_vec3w w2;
    lav_pkg::t_side2 side2_c;
    logic            mat_valid;
    lav_pkg::t_mat   mat;

    // request spacing counter, loaded on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= '0;
        end else if (acc) begin
            r_gap <= 2'd3;
        end else if (r_gap != 2'd0) begin
            r_gap <= r_gap - 2'd1;
        end
    end

    assign busy = r_gap != 2'd0;
    assign acc  = start && !busy;

    assign dir_w[0] = {{32{i_dir_x[31]}}, i_dir_x};
    assign dir_w[1] = {{32{i_dir_y[31]}}, i_dir_y};
    assign dir_w[2] = {{32{i_dir_z[31]}}, i_dir_z};
    assign up_w[0]  = {{32{i_up_x[31]}}, i_up_x};
    assign up_w[1]  = {{32{i_up_y[31]}}, i_up_y};
    assign up_w[2]  = {{32{i_up_z[31]}}, i_up_z};
    assign pos_in   = {i_pos_z, i_pos_y, i_pos_x};

    // n = normalize(dir), position rides along
    lav_norm #(
        .FRAC_BITS (FRAC_BITS),
        .SW        (96)
    ) u_norm_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (acc),
        .i_vec   (dir_w),
        .i_side  (pos_in),
        .o_valid (v_d),
        .o_vec   (n_vec),
        .o_zero  (z_d),
        .o_side  (pos_d)
    );

    // upn = normalize(up)
    lav_norm #(
        .FRAC_BITS (FRAC_BITS),
        .SW        (1)
    ) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (acc),
        .i_vec   (up_w),
        .i_side  (1'b0),
        .o_valid (v_u),
        .o_vec   (upn_vec),
        .o_zero  (z_u),
        .o_side  ()
    );

    assign side1.deg = z_d | z_u;
    assign side1.n   = n_vec;
    assign side1.pos = pos_d;

    // upn x n
    lav_cross #(
        .SW ($bits(lav_pkg::t_side1))
    ) u_cross_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v_d),
        .i_a     (upn_vec),
        .i_b     (n_vec),
        .i_side  (side1),
        .o_valid (v_c1),
        .o_w     (w1),
        .o_side  (side1_c)
    );

    // u = normalize(upn x n)
    lav_norm #(
        .FRAC_BITS (FRAC_BITS),
        .SW        ($bits(lav_pkg::t_side1))
    ) u_norm_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v_c1),
        .i_vec   (w1),
        .i_side  (side1_c),
        .o_valid (v_nw),
        .o_vec   (u_vec),
        .o_zero  (z_w),
        .o_side  (side1_n)
    );

    assign side2.deg = side1_n.deg | z_w;
    assign side2.u   = u_vec;
    assign side2.n   = side1_n.n;
    assign side2.pos = side1_n.pos;

    // n x u, exact
    lav_cross #(
        .SW ($bits(lav_pkg::t_side2))
    ) u_cross_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v_nw),
        .i_a     (side1_n.n),
        .i_b     (u_vec),
        .i_side  (side2),
        .o_valid (v_c2),
        .o_w     (w2),
        .o_side  (side2_c)
    );

    lav_trans #(
        .FRAC_BITS (FRAC_BITS)
    ) u_trans (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v_c2),
        .i_w     (w2),
        .i_side  (side2_c),
        .o_valid (mat_valid),
        .o_mat   (mat)
    );

    lav_ser #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (mat_valid),
        .i_mat          (mat),
        .o_strobe       (o_strobe),
        .o_column_index (o_column_index),
        .o_row0         (o_entry_row0),
        .o_row1         (o_entry_row1),
        .o_row2         (o_entry_row2),
        .o_row3         (o_entry_row3),
        .o_last_column  (o_last_column),
        .o_degenerate   (o_degenerate)
    );

    // checks
    `ASSERT_CLK(a_busy_after_acc, i_clk, i_rst_n, acc |=> busy, "busy not raised after accept")
    `ASSERT_NEVER(a_norm_align, i_clk, i_rst_n, v_d != v_u, "dir and up normalizers out of step")
    `ASSERT_NEVER(a_ser_overrun, i_clk, i_rst_n, mat_valid && o_strobe && !o_last_column, "new matrix while columns still pending")
    `ASSERT_CLK(a_col_seq, i_clk, i_rst_n, o_strobe && !o_last_column |=> o_strobe && (o_column_index == 2'($past(o_column_index) + 2'd1)), "column sequence broken")

endmodule

@@ rtl/lav_norm.sv @@
// Pipelined vector normalizer: scale, sum of squares, square root, divide.
module lav_norm #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF,
    parameter int SW        = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  lav_pkg::t_vec3w i_vec,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output lav_pkg::t_vec3  o_vec,
    output logic            o_zero,
    output logic [SW-1:0]   o_side
);

    localparam int TW        = SW + 4;
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int NW        = 32 + FRAC_BITS;
    localparam int QW        = FRAC_BITS + 1;
    localparam int LAT       = 9 + SQ_STEPS + DIV_STEPS - 1;

    typedef logic [2:0][30:0] t_x3;
    typedef logic [2:0][61:0] t_sq3;
    typedef logic [2:0][NW-1:0] t_dr3;
    typedef logic [2:0][QW-1:0] t_dq3;

    // top bits of the OR word clear: shift all three left
    function automatic lav_pkg::t_vec3w lz_step(input lav_pkg::t_vec3w m, input int amt);
        logic [63:0]     orv;
        lav_pkg::t_vec3w r;
        orv = m[0] | m[1] | m[2];
        r   = m;
        if ((orv >> (64 - amt)) == 64'd0) begin
            for (int k = 0; k < 3; k++) begin
                r[k] = m[k] << amt;
            end
        end
        return r;
    endfunction

    logic [LAT-1:0]  r_vc;
    logic [TW-1:0]   r_tag [LAT-1];
    lav_pkg::t_vec3w r_sh  [4];
    lav_pkg::t_vec3w n_sh  [3];
    lav_pkg::t_vec3w mag_a;
    logic [2:0]      sgn_a;
    logic            zero_a;
    t_x3             r_xc;
    t_sq3            r_sq;
    logic [63:0]     r_s    [SQ_STEPS+1];
    logic [33:0]     r_rem  [SQ_STEPS+1];
    logic [31:0]     r_root [SQ_STEPS+1];
    t_x3             r_xq   [SQ_STEPS+1];
    logic [33:0]     n_rem  [SQ_STEPS];
    logic [31:0]     n_root [SQ_STEPS];
    t_dr3            r_dr   [DIV_STEPS+1];
    t_dq3            r_dq   [DIV_STEPS+1];
    logic [31:0]     r_ld   [DIV_STEPS+1];
    t_dr3            n_dr   [DIV_STEPS];
    t_dq3            n_dq   [DIV_STEPS];
    lav_pkg::t_vec3  r_out;
    logic            r_zero;
    logic [SW-1:0]   r_side;

    // magnitudes and signs
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sgn_a[k] = i_vec[k][63];
            mag_a[k] = lav_pkg::abs64(i_vec[k]);
        end
        zero_a = (mag_a[0] | mag_a[1] | mag_a[2]) == 64'd0;
    end

    // leading-zero shift, two binary steps per stage
    always_comb begin
        for (int b = 0; b < 3; b++) begin
            n_sh[b] = lz_step(lz_step(r_sh[b], 32 >> (2 * b)), 16 >> (2 * b));
        end
    end

    // square root, one result bit per stage
    always_comb begin
        logic [35:0] rem2;
        logic [35:0] trial;
        for (int j = 0; j < SQ_STEPS; j++) begin
            rem2  = {r_rem[j], r_s[j][63:62]};
            trial = {2'b00, r_root[j], 2'b01};
            if (rem2 >= trial) begin
                n_rem[j]  = 34'(rem2 - trial);
                n_root[j] = {r_root[j][30:0], 1'b1};
            end else begin
                n_rem[j]  = 34'(rem2);
                n_root[j] = {r_root[j][30:0], 1'b0};
            end
        end
    end

    // restoring division, one quotient bit per stage
    always_comb begin
        logic [NW-1:0] d;
        for (int s = 0; s < DIV_STEPS; s++) begin
            d = NW'(r_ld[s]) << (FRAC_BITS - s);
            for (int k = 0; k < 3; k++) begin
                if (r_dr[s][k] >= d) begin
                    n_dr[s][k] = r_dr[s][k] - d;
                    n_dq[s][k] = r_dq[s][k] | (QW'(1) << (FRAC_BITS - s));
                end else begin
                    n_dr[s][k] = r_dr[s][k];
                    n_dq[s][k] = r_dq[s][k];
                end
            end
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= '0;
        end else begin
            r_vc <= {r_vc[LAT-2:0], i_valid};
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_tag[0] <= {i_side, sgn_a, zero_a};
        for (int i = 1; i < LAT - 1; i++) begin
            r_tag[i] <= r_tag[i-1];
        end
        r_sh[0] <= mag_a;
        for (int b = 0; b < 3; b++) begin
            r_sh[b+1] <= n_sh[b];
        end
        for (int k = 0; k < 3; k++) begin
            r_xc[k] <= r_sh[3][k][63:33];
            r_sq[k] <= 62'(r_sh[3][k][63:33]) * 62'(r_sh[3][k][63:33]);
        end
        r_s[0]    <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_xq[0]   <= r_xc;
        for (int j = 0; j < SQ_STEPS; j++) begin
            r_s[j+1]    <= r_s[j] << 2;
            r_rem[j+1]  <= n_rem[j];
            r_root[j+1] <= n_root[j];
            r_xq[j+1]   <= r_xq[j];
        end
        // dividend m << F plus half the length for rounding
        for (int k = 0; k < 3; k++) begin
            r_dr[0][k] <= (NW'(r_xq[SQ_STEPS][k]) << FRAC_BITS)
                          + NW'(r_root[SQ_STEPS] >> 1);
        end
        r_dq[0] <= '0;
        r_ld[0] <= r_root[SQ_STEPS];
        for (int s = 0; s < DIV_STEPS; s++) begin
            r_dr[s+1] <= n_dr[s];
            r_dq[s+1] <= n_dq[s];
            r_ld[s+1] <= r_ld[s];
        end
        // restore signs, zero vector gives zero
        for (int k = 0; k < 3; k++) begin
            if (r_tag[LAT-2][0]) begin
                r_out[k] <= '0;
            end else if (r_tag[LAT-2][k+1]) begin
                r_out[k] <= 32'd0 - 32'(r_dq[DIV_STEPS][k]);
            end else begin
                r_out[k] <= 32'(r_dq[DIV_STEPS][k]);
            end
        end
        r_zero <= r_tag[LAT-2][0];
        r_side <= r_tag[LAT-2][TW-1:4];
    end

    assign o_valid = r_vc[LAT-1];
    assign o_vec   = r_out;
    assign o_zero  = r_zero;
    assign o_side  = r_side;

endmodule

@@ rtl/lav_cross.sv @@
// Two-stage exact cross product a x b in Q(2F).
module lav_cross #(
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  lav_pkg::t_vec3  i_a,
    input  lav_pkg::t_vec3  i_b,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output lav_pkg::t_vec3w o_w,
    output logic [SW-1:0]   o_side
);

    localparam int I1 [3] = '{1, 2, 0};
    localparam int I2 [3] = '{2, 0, 1};

    logic [1:0]      r_v;
    lav_pkg::t_vec3w n_pp;
    lav_pkg::t_vec3w n_pn;
    lav_pkg::t_vec3w r_pp;
    lav_pkg::t_vec3w r_pn;
    lav_pkg::t_vec3w r_w;
    logic [SW-1:0]   r_side [2];

    // six signed products
    always_comb begin
        logic signed [31:0] a1;
        logic signed [31:0] a2;
        logic signed [31:0] b1;
        logic signed [31:0] b2;
        logic signed [63:0] p;
        logic signed [63:0] q;
        for (int k = 0; k < 3; k++) begin
            a1      = i_a[I1[k]];
            a2      = i_a[I2[k]];
            b1      = i_b[I1[k]];
            b2      = i_b[I2[k]];
            p       = a1 * b2;
            q       = a2 * b1;
            n_pp[k] = p;
            n_pn[k] = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp      <= n_pp;
        r_pn      <= n_pn;
        r_side[0] <= i_side;
        for (int k = 0; k < 3; k++) begin
            r_w[k] <= r_pp[k] - r_pn[k];
        end
        r_side[1] <= r_side[0];
    end

    assign o_valid = r_v[1];
    assign o_w     = r_w;
    assign o_side  = r_side[1];

endmodule

@@ rtl/lav_trans.sv @@
// Rounds v, forms the three negated dot products with p and saturates them.
module lav_trans #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  lav_pkg::t_vec3w i_w,
    input  lav_pkg::t_side2 i_side,
    output logic            o_valid,
    output lav_pkg::t_mat   o_mat
);

    localparam logic signed [63:0] MAX32 = 64'sd2147483647;
    localparam logic signed [63:0] MIN32 = -64'sd2147483648;

    // Q(2F) to Q.F, nearest with halves away from zero
    function automatic logic [63:0] rnd(input logic [63:0] a);
        logic [63:0] m;
        logic [63:0] q;
        m = lav_pkg::abs64(a);
        q = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return a[63] ? (64'd0 - q) : q;
    endfunction

    function automatic logic [31:0] sat32(input logic [63:0] a);
        logic signed [63:0] s;
        s = a;
        if (s > MAX32) begin
            return 32'h7FFF_FFFF;
        end else if (s < MIN32) begin
            return 32'h8000_0000;
        end
        return a[31:0];
    endfunction

    logic [4:0]      r_v;
    lav_pkg::t_vec3  r_u   [5];
    lav_pkg::t_vec3  r_vv  [5];
    lav_pkg::t_vec3  r_n   [5];
    logic            r_deg [5];
    lav_pkg::t_vec3  r_pos;
    lav_pkg::t_vec3w r_pu;
    lav_pkg::t_vec3w r_pv;
    lav_pkg::t_vec3w r_pn;
    lav_pkg::t_vec3w n_pu;
    lav_pkg::t_vec3w n_pv;
    lav_pkg::t_vec3w n_pn;
    logic [2:0][63:0] r_sum;
    logic [2:0][63:0] r_rnd;
    lav_pkg::t_vec3  r_t;

    // products with the position
    always_comb begin
        logic signed [31:0] pk;
        logic signed [31:0] uk;
        logic signed [31:0] vk;
        logic signed [31:0] nk;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] c;
        for (int k = 0; k < 3; k++) begin
            pk      = r_pos[k];
            uk      = r_u[0][k];
            vk      = r_vv[0][k];
            nk      = r_n[0][k];
            a       = uk * pk;
            b       = vk * pk;
            c       = nk * pk;
            n_pu[k] = a;
            n_pv[k] = b;
            n_pn[k] = c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // round v
        for (int k = 0; k < 3; k++) begin
            r_vv[0][k] <= 32'(rnd(i_w[k]));
        end
        r_u[0]   <= i_side.u;
        r_n[0]   <= i_side.n;
        r_deg[0] <= i_side.deg;
        r_pos    <= i_side.pos;
        for (int i = 1; i < 5; i++) begin
            r_u[i]   <= r_u[i-1];
            r_vv[i]  <= r_vv[i-1];
            r_n[i]   <= r_n[i-1];
            r_deg[i] <= r_deg[i-1];
        end
        r_pu <= n_pu;
        r_pv <= n_pv;
        r_pn <= n_pn;
        r_sum[0] <= r_pu[0] + r_pu[1] + r_pu[2];
        r_sum[1] <= r_pv[0] + r_pv[1] + r_pv[2];
        r_sum[2] <= r_pn[0] + r_pn[1] + r_pn[2];
        for (int k = 0; k < 3; k++) begin
            r_rnd[k] <= rnd(64'd0 - r_sum[k]);
            r_t[k]   <= sat32(r_rnd[k]);
        end
    end

    assign o_valid   = r_v[4];
    assign o_mat.deg = r_deg[4];
    assign o_mat.u   = r_u[4];
    assign o_mat.v   = r_vv[4];
    assign o_mat.n   = r_n[4];
    assign o_mat.t   = r_t;

endmodule

@@ rtl/lav_ser.sv @@
// Holds one matrix and sends it out a column per cycle.
module lav_ser #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  lav_pkg::t_mat i_mat,
    output logic          o_strobe,
    output logic [1:0]    o_column_index,
    output logic [31:0]   o_row0,
    output logic [31:0]   o_row1,
    output logic [31:0]   o_row2,
    output logic [31:0]   o_row3,
    output logic          o_last_column,
    output logic          o_degenerate
);

    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

    logic          r_act;
    logic [1:0]    r_col;
    lav_pkg::t_mat r_mat;

    // column counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_col <= '0;
        end else if (i_valid) begin
            r_act <= 1'b1;
            r_col <= '0;
        end else if (r_act) begin
            r_col <= r_col + 2'd1;
            if (r_col == lav_pkg::LAST_COL) begin
                r_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_mat <= i_mat;
        end
    end

    // column select
    always_comb begin
        if (r_col == lav_pkg::LAST_COL) begin
            o_row0 = r_mat.t[0];
            o_row1 = r_mat.t[1];
            o_row2 = r_mat.t[2];
            o_row3 = ONE;
        end else begin
            o_row0 = r_mat.u[r_col];
            o_row1 = r_mat.v[r_col];
            o_row2 = r_mat.n[r_col];
            o_row3 = '0;
        end
    end

    assign o_strobe       = r_act;
    assign o_column_index = r_col;
    assign o_last_column  = r_col == lav_pkg::LAST_COL;
    assign o_degenerate   = r_mat.deg;

endmodule
